// File: src/swrm_pkg.sv
// swrm_pkg: shared types, constants and bank decode helpers for the bank mapper
// used by the decode, top level and checker modules; depends on nothing

package swrm_pkg;

    // sizes
    localparam int NUM_WIN    = 6;
    localparam int WIN_BITS   = 3;
    localparam int PAGE_BITS  = 13;
    localparam int RAM_BYTES  = 8192;
    localparam int RAM_AW     = $clog2(RAM_BYTES);
    localparam int ROM_BYTES  = 1048576;
    localparam int ROM_AW     = 21;
    localparam int BASE_W     = 20;
    localparam int CLR_W      = RAM_AW + 1;

    localparam logic [ROM_AW-1:0] ROM_MASK = ROM_AW'(ROM_BYTES - 1);

    // access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // bank byte decode
    localparam logic [7:0] BANK_MASK    = 8'hF4;
    localparam logic [7:0] BANK_EMPTY   = 8'h80;
    localparam logic [7:0] BANK_RAM     = 8'h84;
    localparam logic [7:0] BANK_RESET   = 8'hA8;
    localparam logic [7:0] OPEN_BUS     = 8'hFF;

    // register addresses
    localparam logic [15:0] ADDR_BANK0  = 16'h6400;
    localparam logic [15:0] ADDR_BANK1  = 16'h6C00;
    localparam logic [15:0] ADDR_BANK2  = 16'h6000;
    localparam logic [15:0] ADDR_BANK3  = 16'h6800;
    localparam logic [15:0] ADDR_BANK4  = 16'h7000;
    localparam logic [15:0] ADDR_BANK5  = 16'h7800;
    localparam logic [15:0] ADDR_CTRL   = 16'h7FF9;
    localparam logic [15:0] ADDR_RBACK  = 16'h7FF0;
    localparam int          CTRL_RB_BIT = 2;

    typedef logic [NUM_WIN-1:0][7:0] t_bank_arr;

    // everything the decode stage decides for one access
    typedef struct packed {
        logic [NUM_WIN-1:0] bank_we;
        logic               ctrl_we;
        logic               ram_we;
        logic               ram_re;
        logic [RAM_AW-1:0]  ram_addr;
        logic [7:0]         read_data;
        logic               from_rom;
        logic [ROM_AW-1:0]  rom_address;
    } t_dec;

    function automatic logic is_empty(input logic [7:0] b);
        return (b & BANK_MASK) == BANK_EMPTY;
    endfunction

    function automatic logic is_ram(input logic [7:0] b);
        return (b & BANK_MASK) == BANK_RAM;
    endfunction

endpackage

// File: src/swrm_ram.sv
// swrm_ram: generic single-port RAM with registered read and read enable
// no dependencies

module swrm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8192
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one access per cycle, read data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/swrm_decode.sv
// swrm_decode: combinational decode of one bus access against the bank state
// depends on swrm_pkg

module swrm_decode (
    input  logic                          i_cmd,
    input  logic [15:0]                   i_address,
    input  logic [7:0]                    i_write_data,
    input  swrm_pkg::t_bank_arr           i_bank,
    input  logic [7:0]                    i_ctrl,
    input  logic [swrm_pkg::BASE_W-1:0]   i_rom_base,
    output swrm_pkg::t_dec                o_dec
);

    logic                                 in_range;
    logic [swrm_pkg::WIN_BITS-1:0]        win;
    logic                                 rb_hit;
    logic [swrm_pkg::NUM_WIN-1:0]         bank_hit;
    logic                                 ctrl_hit;
    logic [swrm_pkg::WIN_BITS-1:0]        rd_idx;
    logic [7:0]                           bank_rd;
    logic                                 own_bank_hit;
    logic [7:0]                           eff_bank;
    logic [swrm_pkg::ROM_AW-1:0]          page;
    logic [swrm_pkg::ROM_AW-1:0]          offset;

    assign in_range = (i_address[15:14] != 2'b11);
    assign win      = i_address[15:13];
    assign rb_hit   = (i_address[15:3] == swrm_pkg::ADDR_RBACK[15:3])
                      && i_ctrl[swrm_pkg::CTRL_RB_BIT];

    // register address decode
    always_comb begin
        bank_hit = '0;
        ctrl_hit = 1'b0;
        unique case (i_address)
            swrm_pkg::ADDR_BANK0: bank_hit[0] = 1'b1;
            swrm_pkg::ADDR_BANK1: bank_hit[1] = 1'b1;
            swrm_pkg::ADDR_BANK2: bank_hit[2] = 1'b1;
            swrm_pkg::ADDR_BANK3: bank_hit[3] = 1'b1;
            swrm_pkg::ADDR_BANK4: bank_hit[4] = 1'b1;
            swrm_pkg::ADDR_BANK5: bank_hit[5] = 1'b1;
            swrm_pkg::ADDR_CTRL:  ctrl_hit    = 1'b1;
            default: ;
        endcase
    end

    // single bank read port: readback slot or the window's own bank
    assign rd_idx  = (rb_hit && i_cmd == swrm_pkg::CMD_READ) ? i_address[2:0] : win;
    assign bank_rd = (rd_idx < swrm_pkg::WIN_BITS'(swrm_pkg::NUM_WIN)) ? i_bank[rd_idx] : 8'h00;

    // a bank write to the window's own bank takes effect before the ram check
    always_comb begin
        own_bank_hit = 1'b0;
        for (int w = 0; w < swrm_pkg::NUM_WIN; w++) begin
            if (bank_hit[w] && win == swrm_pkg::WIN_BITS'(w)) begin
                own_bank_hit = 1'b1;
            end
        end
    end
    assign eff_bank = own_bank_hit ? i_write_data : bank_rd;

    // rom address: page from bank byte, then base and page offset
    assign page   = {bank_rd, swrm_pkg::PAGE_BITS'(0)} & swrm_pkg::ROM_MASK;
    assign offset = swrm_pkg::ROM_AW'(i_address[swrm_pkg::PAGE_BITS-1:0]);

    always_comb begin
        o_dec             = '0;
        o_dec.ram_addr    = i_address[swrm_pkg::RAM_AW-1:0];
        if (i_cmd == swrm_pkg::CMD_WRITE) begin
            if (in_range) begin
                o_dec.bank_we = bank_hit;
                o_dec.ctrl_we = ctrl_hit;
                o_dec.ram_we  = swrm_pkg::is_ram(eff_bank);
            end
        end else if (!in_range) begin
            o_dec.read_data = swrm_pkg::OPEN_BUS;
        end else if (rb_hit) begin
            o_dec.read_data = (i_address[2:1] == 2'b11) ? 8'h00 : bank_rd;
        end else if (swrm_pkg::is_empty(bank_rd)) begin
            o_dec.read_data = swrm_pkg::OPEN_BUS;
        end else if (swrm_pkg::is_ram(bank_rd)) begin
            o_dec.ram_re = 1'b1;
        end else begin
            o_dec.from_rom    = 1'b1;
            o_dec.rom_address = swrm_pkg::ROM_AW'({1'b0, i_rom_base} + (page | offset));
        end
    end

endmodule

// File: src/six_window_rom_ram_bank_mapper_top.sv
// six_window_rom_ram_bank_mapper_top: bank mapper top level, pipeline and state
// depends on swrm_pkg, swrm_decode and swrm_ram
//
// Usage:
//   input channel  (i_valid / o_stall): one bus access per transfer, fields
//   i_cmd, i_address, i_write_data. Every access gives exactly one result.
//   output channel (o_valid / i_stall): o_read_data, o_from_rom, o_rom_address.
//   For a ROM read o_from_rom is set and the external ROM byte at o_rom_address
//   is the data; otherwise o_read_data holds the byte (0 on writes).
//   config channel (i_cfg_valid / o_cfg_ready): writes rom_base; always ready;
//   the user writes it only while no access is in flight; the block does not check this.
// Timing:
//   one access per cycle sustained while i_stall is low; each access reaches the
//   output through input register, decode plus ram access, result reg.
//   The single ram port carries one read or write per cycle, in access order.
// Reset:
//   banks go to 0xA8, control to 0, rom_base to 0. The 8 KB ram is then
//   cleared one byte a cycle: o_stall stays high until every byte is cleared.
// Stall:
//   while i_stall is high the result holds; the pipeline fills behind it and
//   o_stall rises once all three stages are occupied.

module six_window_rom_ram_bank_mapper_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_cmd,
    input  logic [15:0]                         i_address,
    input  logic [7:0]                          i_write_data,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [7:0]                          o_read_data,
    output logic                                o_from_rom,
    output logic [swrm_pkg::ROM_AW-1:0]         o_rom_address,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [swrm_pkg::BASE_W-1:0]         i_rom_base
);

    // state
    swrm_pkg::t_bank_arr                r_bank;
    logic [7:0]                         r_ctrl;
    logic [swrm_pkg::BASE_W-1:0]        r_rom_base;
    logic                               r_clr_busy;
    logic [swrm_pkg::CLR_W-1:0]         r_clr_cnt;

    // input stage
    logic                               r_a_valid;
    logic                               r_a_cmd;
    logic [15:0]                        r_a_address;
    logic [7:0]                         r_a_write_data;

    // ram stage
    logic                               r_b_valid;
    logic                               r_b_use_ram;
    logic [7:0]                         r_b_read_data;
    logic                               r_b_from_rom;
    logic [swrm_pkg::ROM_AW-1:0]        r_b_rom_address;

    // result stage
    logic                               r_out_valid;
    logic [7:0]                         r_out_read_data;
    logic                               r_out_from_rom;
    logic [swrm_pkg::ROM_AW-1:0]        r_out_rom_address;

    swrm_pkg::t_dec                     dec;
    logic                               in_xfer;
    logic                               a_adv;
    logic                               b_adv;
    logic                               ram_en;
    logic                               ram_we;
    logic [swrm_pkg::RAM_AW-1:0]        ram_addr;
    logic [7:0]                         ram_wdata;
    logic [7:0]                         ram_rdata;
    logic [swrm_pkg::CLR_W-1:0]         n_clr_cnt;

    // pipeline flow control
    assign b_adv   = r_b_valid && (!r_out_valid || !i_stall);
    assign a_adv   = r_a_valid && (!r_b_valid || b_adv);
    assign o_stall = r_clr_busy || (r_a_valid && !a_adv);
    assign in_xfer = i_valid && !o_stall;

    swrm_decode u_decode (
        .i_cmd        (r_a_cmd),
        .i_address    (r_a_address),
        .i_write_data (r_a_write_data),
        .i_bank       (r_bank),
        .i_ctrl       (r_ctrl),
        .i_rom_base   (r_rom_base),
        .o_dec        (dec)
    );

    // ram port: clearing pass first, then one access per advancing item
    assign ram_en    = r_clr_busy || (a_adv && (dec.ram_we || dec.ram_re));
    assign ram_we    = r_clr_busy || dec.ram_we;
    assign ram_addr  = r_clr_busy ? r_clr_cnt[swrm_pkg::RAM_AW-1:0] : dec.ram_addr;
    assign ram_wdata = r_clr_busy ? 8'h00 : r_a_write_data;

    swrm_ram #(
        .WIDTH (8),
        .DEPTH (swrm_pkg::RAM_BYTES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // clearing pass counter
    assign n_clr_cnt = r_clr_cnt + swrm_pkg::CLR_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= n_clr_cnt;
            if (n_clr_cnt == swrm_pkg::CLR_W'(swrm_pkg::RAM_BYTES)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_base <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_rom_base <= i_rom_base;
        end
    end

    // bank and control registers, updated as an item leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank <= {swrm_pkg::NUM_WIN{swrm_pkg::BANK_RESET}};
            r_ctrl <= '0;
        end else if (a_adv) begin
            for (int w = 0; w < swrm_pkg::NUM_WIN; w++) begin
                if (dec.bank_we[w]) begin
                    r_bank[w] <= r_a_write_data;
                end
            end
            if (dec.ctrl_we) begin
                r_ctrl <= r_a_write_data;
            end
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_xfer) begin
            r_a_valid <= 1'b1;
        end else if (a_adv) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_a_cmd        <= i_cmd;
            r_a_address    <= i_address;
            r_a_write_data <= i_write_data;
        end
    end

    // ram stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_adv) begin
            r_b_valid <= 1'b1;
        end else if (b_adv) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b_use_ram     <= dec.ram_re;
            r_b_read_data   <= dec.read_data;
            r_b_from_rom    <= dec.from_rom;
            r_b_rom_address <= dec.rom_address;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (b_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_out_read_data   <= r_b_use_ram ? ram_rdata : r_b_read_data;
            r_out_from_rom    <= r_b_from_rom;
            r_out_rom_address <= r_b_rom_address;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_read_data   = r_out_read_data;
    assign o_from_rom    = r_out_from_rom;
    assign o_rom_address = r_out_rom_address;

endmodule

// File: src/swrm_checker.sv
// swrm_checker: port-level checks of the bank mapper, bound to the top level
// depends on swrm_pkg

module swrm_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_stall,
    input  logic                          o_valid,
    input  logic                          i_stall,
    input  logic [7:0]                    o_read_data,
    input  logic                          o_from_rom,
    input  logic [swrm_pkg::ROM_AW-1:0]   o_rom_address
);

    // a stalled result holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_read_data)
        && $stable(o_from_rom) && $stable(o_rom_address))
        else $error("stalled result changed");

    // rom address only on rom reads
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_from_rom |-> o_rom_address == '0)
        else $error("rom address set without rom read");

    // read data is zero when the byte comes from rom
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_from_rom |-> o_read_data == 8'h00)
        else $error("read data set on rom read");

    // reset empties the pipeline and starts the ram clearing pass
    assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_stall)
        else $error("pipeline not idle after reset");

endmodule

bind six_window_rom_ram_bank_mapper_top swrm_checker u_swrm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_read_data   (o_read_data),
    .o_from_rom    (o_from_rom),
    .o_rom_address (o_rom_address)
);
